[rtl/core/masked_byte_expand_rows_macros.svh]
// Assertion helpers for the byte expander.
`ifndef MASKED_BYTE_EXPAND_ROWS_MACROS_SVH
`define MASKED_BYTE_EXPAND_ROWS_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define MBER_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mber: check failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define MBER_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mber: check failed");

`endif

[rtl/core/mber_pkg.sv]
`timescale 1ns / 1ps

package mber_pkg;

  localparam int RowBytes    = 64;
  localparam int LaneNum     = 8;
  localparam int LaneBytes   = 8;
  localparam int CounterSpan = 64;

  typedef logic [RowBytes-1:0][7:0]  mber_window_t;
  typedef logic [LaneNum-1:0][3:0]   mber_lane_cnt_t;

  typedef struct packed {
    logic [LaneNum-1:0][5:0] lane_base;
    logic [6:0]              total;
  } mber_base_t;

  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      acc = acc + 4'(v[i]);
    end
    return acc;
  endfunction

endpackage

[rtl/core/mber_if.sv]
`timescale 1ns / 1ps

interface mber_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] row_mask;
  logic [63:0] packed_word0;
  logic [63:0] packed_word1;
  logic [63:0] packed_word2;
  logic [63:0] packed_word3;
  logic [63:0] packed_word4;
  logic [63:0] packed_word5;
  logic [63:0] packed_word6;
  logic [63:0] packed_word7;

  modport source (
    output valid, row_mask, packed_word0, packed_word1, packed_word2, packed_word3,
           packed_word4, packed_word5, packed_word6, packed_word7,
    input  ready
  );
  modport sink (
    input  valid, row_mask, packed_word0, packed_word1, packed_word2, packed_word3,
           packed_word4, packed_word5, packed_word6, packed_word7,
    output ready
  );
endinterface

interface mber_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] row_word0;
  logic [63:0] row_word1;
  logic [63:0] row_word2;
  logic [63:0] row_word3;
  logic [63:0] row_word4;
  logic [63:0] row_word5;
  logic [63:0] row_word6;
  logic [63:0] row_word7;
  logic [6:0]  bytes_used;
  logic [5:0]  row_number;
  logic        last_row;

  modport source (
    output valid, row_word0, row_word1, row_word2, row_word3, row_word4, row_word5,
           row_word6, row_word7, bytes_used, row_number, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_word0, row_word1, row_word2, row_word3, row_word4, row_word5,
           row_word6, row_word7, bytes_used, row_number, last_row,
    output ready
  );
endinterface

[rtl/core/mber_lane.sv]
`timescale 1ns / 1ps

module mber_lane
  import mber_pkg::*;
(
  input  logic [LaneBytes-1:0] lane_mask_i,
  input  logic [5:0]           lane_base_i,
  input  mber_window_t         window_i,
  output logic [63:0]          lane_word_o
);

  logic [2:0] run;
  logic [5:0] idx;

  always_comb begin
    run         = '0;
    idx         = '0;
    lane_word_o = '0;
    for (int k = 0; k < LaneBytes; k++) begin
      idx = lane_base_i + 6'(run);
      if (lane_mask_i[k]) begin
        lane_word_o[8*k +: 8] = window_i[idx];
      end
      run = run + 3'(lane_mask_i[k]);
    end
  end

endmodule

[rtl/core/mber_prefix.sv]
`timescale 1ns / 1ps

module mber_prefix
  import mber_pkg::*;
(
  input  mber_lane_cnt_t lane_cnt_i,
  output mber_base_t     base_o
);

  logic [6:0] acc;

  always_comb begin
    acc    = '0;
    base_o = '0;
    for (int l = 0; l < LaneNum; l++) begin
      base_o.lane_base[l] = acc[5:0];
      acc = acc + 7'(lane_cnt_i[l]);
    end
    base_o.total = acc;
  end

endmodule

[rtl/core/masked_byte_expand_rows.sv]
`timescale 1ns / 1ps
// Bitmask sparse row expander.
// in_chan_i carries one beat per 64-byte row: a 64-bit mask and a window of
// 64 packed bytes. out_chan_o returns the expanded row as eight words, the
// count of packed bytes consumed (the feeder advances its window by that),
// the row index within the block and a last-row flag.
// Throughput: one beat per cycle in and out while out_chan_o takes each beat.
// An accepted beat passes through registered stages before out_chan_o: lane
// counts, lane offsets, then eight lanes expand into the output register.
// Stall: when out_chan_o is not taken, the output register holds its beat;
// the pipeline keeps filling its empty stages and in_chan_i.ready drops only
// once every stage holds a beat.
// Reset: all stages empty, row counter back to row 0.
// Block length is ROWS_PER_BLOCK clamped to 1..64; the counter wraps to 0
// after the last row.
`include "masked_byte_expand_rows_macros.svh"

module masked_byte_expand_rows
  import mber_pkg::*;
#(
  parameter int ROWS_PER_BLOCK = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mber_in_if.sink   in_chan_i,
  mber_out_if.source out_chan_o
);

  localparam int BlockLen = (ROWS_PER_BLOCK < 1) ? 1 :
                            ((ROWS_PER_BLOCK > CounterSpan) ? CounterSpan : ROWS_PER_BLOCK);
  localparam logic [5:0] LastIdx = 6'(BlockLen - 1);

  logic en1, en2, en3, in_acc;

  mber_window_t   win_in;
  mber_lane_cnt_t cnt_in;
  logic [5:0]     cnt_q, cnt_d, cur;
  logic           cur_last;

  logic           v1_q, v2_q, ov_q;
  logic [63:0]    mask1_q, mask2_q;
  mber_window_t   win1_q, win2_q;
  mber_lane_cnt_t cnt1_q;
  logic [5:0]     rown1_q, rown2_q, rown_q;
  logic           last1_q, last2_q, last_q;
  mber_base_t     base, base2_q;
  logic [LaneNum-1:0][63:0] lane_word, row_q;
  logic [6:0]     used_q;

  assign en3    = !ov_q || out_chan_o.ready;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign in_acc = in_chan_i.valid && en1;
  assign in_chan_i.ready = en1;

  assign win_in = {in_chan_i.packed_word7, in_chan_i.packed_word6, in_chan_i.packed_word5,
                   in_chan_i.packed_word4, in_chan_i.packed_word3, in_chan_i.packed_word2,
                   in_chan_i.packed_word1, in_chan_i.packed_word0};

  always_comb begin
    for (int l = 0; l < LaneNum; l++) begin
      cnt_in[l] = popcnt8(in_chan_i.row_mask[LaneBytes*l +: LaneBytes]);
    end
  end

  assign cur      = (cnt_q > LastIdx) ? LastIdx : cnt_q;
  assign cur_last = (cur == LastIdx);
  assign cnt_d    = cur_last ? '0 : cur + 6'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_q <= cnt_d;
      end
      if (en1) begin
        v1_q <= in_chan_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        ov_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mask1_q <= in_chan_i.row_mask;
      win1_q  <= win_in;
      cnt1_q  <= cnt_in;
      rown1_q <= cur;
      last1_q <= cur_last;
    end
    if (en2) begin
      mask2_q <= mask1_q;
      win2_q  <= win1_q;
      base2_q <= base;
      rown2_q <= rown1_q;
      last2_q <= last1_q;
    end
    if (en3) begin
      row_q  <= lane_word;
      used_q <= base2_q.total;
      rown_q <= rown2_q;
      last_q <= last2_q;
    end
  end

  mber_prefix u_prefix (
    .lane_cnt_i (cnt1_q),
    .base_o     (base)
  );

  for (genvar l = 0; l < LaneNum; l++) begin : g_lane
    mber_lane u_lane (
      .lane_mask_i (mask2_q[LaneBytes*l +: LaneBytes]),
      .lane_base_i (base2_q.lane_base[l]),
      .window_i    (win2_q),
      .lane_word_o (lane_word[l])
    );
  end

  assign out_chan_o.valid      = ov_q;
  assign out_chan_o.row_word0  = row_q[0];
  assign out_chan_o.row_word1  = row_q[1];
  assign out_chan_o.row_word2  = row_q[2];
  assign out_chan_o.row_word3  = row_q[3];
  assign out_chan_o.row_word4  = row_q[4];
  assign out_chan_o.row_word5  = row_q[5];
  assign out_chan_o.row_word6  = row_q[6];
  assign out_chan_o.row_word7  = row_q[7];
  assign out_chan_o.bytes_used = used_q;
  assign out_chan_o.row_number = rown_q;
  assign out_chan_o.last_row   = last_q;

  `MBER_ASSERT_IMPL(a_total_popcount, v2_q, base2_q.total == 7'($countones(mask2_q)))
  `MBER_ASSERT_IMPL(a_row_in_block, ov_q, rown_q <= LastIdx)
  `MBER_ASSERT_IMPL(a_last_flag, ov_q, last_q == (rown_q == LastIdx))
  `MBER_ASSERT_NEXT(a_counter_step, in_acc,
                    cnt_q == ($past(cur_last) ? 6'd0 : $past(cur) + 6'd1))

endmodule
